>>> sv/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;
	localparam int OCC_W  = 7;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_LIST_FWD   = 3'd4;
	localparam logic [OP_W-1:0] OP_LIST_REV   = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	typedef struct packed {
		logic do_req;
		logic list_start;
		logic list_step;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic list_last;
	} sts_t;

endpackage
`default_nettype wire

>>> sv/deq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> sv/deq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module deq_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [deq_pkg::OP_W-1:0] opcode,
	input  wire deq_pkg::sts_t            sts,
	output deq_pkg::cmd_t                 cmd,
	output logic                          busy
);

	deq_pkg::state_t state_q;
	deq_pkg::state_t state_d;
	logic            accept;
	logic            is_list;

	assign busy    = (state_q == deq_pkg::S_LIST);
	assign accept  = start && !busy;
	assign is_list = (opcode == deq_pkg::OP_LIST_FWD) || (opcode == deq_pkg::OP_LIST_REV);

	always_comb begin
		state_d        = state_q;
		cmd.do_req     = 1'b0;
		cmd.list_start = 1'b0;
		cmd.list_step  = 1'b0;
		case (state_q)
			deq_pkg::S_IDLE: begin
				if (accept) begin
					cmd.do_req = 1'b1;
					if (is_list && !sts.empty) begin
						cmd.list_start = 1'b1;
						state_d        = deq_pkg::S_LIST;
					end
				end
			end
			deq_pkg::S_LIST: begin
				cmd.list_step = 1'b1;
				if (sts.list_last) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> sv/deq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module deq_datapath #(
	parameter int DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire deq_pkg::cmd_t                     cmd,
	input  wire logic        [deq_pkg::OP_W-1:0]   opcode,
	input  wire logic signed [deq_pkg::DATA_W-1:0] value,
	output deq_pkg::sts_t                          sts,
	output logic                                   strobe,
	output logic signed      [deq_pkg::DATA_W-1:0] element,
	output logic             [deq_pkg::ST_W-1:0]   status,
	output logic             [deq_pkg::OCC_W-1:0]  occupancy,
	output logic                                   last
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_P = (AW+1)'(DEPTH);
	localparam logic [FW-1:0] FULL_P  = FW'(DEPTH);
	localparam logic [AW-1:0] LAST_P  = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] ring(input logic [AW:0] pos);
		logic [AW:0] r;
		r = (pos >= DEPTH_P) ? pos - DEPTH_P : pos;
		return r[AW-1:0];
	endfunction

	logic [AW-1:0] front_q;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] cnt_q;
	logic          list_rev_q;

	logic                      valid_s1;
	logic [deq_pkg::ST_W-1:0]  status_s1;
	logic [FW-1:0]             occ_s1;
	logic                      last_s1;
	logic                      rd_s1;

	logic                        strobe_q;
	logic [deq_pkg::DATA_W-1:0]  element_q;
	logic [deq_pkg::ST_W-1:0]    status_q;
	logic [FW-1:0]               occ_q;
	logic                        last_q;

	logic                       is_push;
	logic                       is_pop;
	logic                       is_list;
	logic                       full;
	logic                       empty;
	logic [FW-1:0]              fill_m1;
	logic [AW-1:0]              list_off;
	logic [FW-1:0]              rd_off;
	logic [AW-1:0]              raddr;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              front_dec;
	logic [AW-1:0]              front_inc;
	logic                       we;
	logic [deq_pkg::DATA_W-1:0] rdata;

	logic                     valid_d;
	logic [deq_pkg::ST_W-1:0] status_d;
	logic [FW-1:0]            occ_d;
	logic                     last_d;
	logic                     rd_d;

	assign is_push = (opcode == deq_pkg::OP_PUSH_FRONT) || (opcode == deq_pkg::OP_PUSH_BACK);
	assign is_pop  = (opcode == deq_pkg::OP_POP_FRONT) || (opcode == deq_pkg::OP_POP_BACK);
	assign is_list = (opcode == deq_pkg::OP_LIST_FWD) || (opcode == deq_pkg::OP_LIST_REV);
	assign full    = (fill_q == FULL_P);
	assign empty   = (fill_q == '0);
	assign fill_m1 = fill_q - FW'(1);

	assign sts.empty     = empty;
	assign sts.list_last = (cnt_q == fill_m1[AW-1:0]);

	assign list_off = list_rev_q ? (fill_m1[AW-1:0] - cnt_q) : cnt_q;

	always_comb begin
		if (cmd.list_step) begin
			rd_off = FW'(list_off);
		end else if (opcode == deq_pkg::OP_POP_BACK) begin
			rd_off = fill_m1;
		end else begin
			rd_off = '0;
		end
	end

	assign raddr     = ring({1'b0, front_q} + (AW+1)'(rd_off));
	assign front_dec = (front_q == '0) ? LAST_P : front_q - AW'(1);
	assign front_inc = ring({1'b0, front_q} + (AW+1)'(1));
	assign waddr     = (opcode == deq_pkg::OP_PUSH_FRONT) ? front_dec
	                 : ring({1'b0, front_q} + (AW+1)'(fill_q));
	assign we        = cmd.do_req && is_push && !full;

	deq_ram #(
		.WIDTH(deq_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		valid_d  = 1'b0;
		status_d = deq_pkg::ST_OK;
		occ_d    = fill_q;
		last_d   = 1'b1;
		rd_d     = 1'b0;
		if (cmd.do_req) begin
			if (is_push) begin
				valid_d = 1'b1;
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					occ_d = fill_q + FW'(1);
				end
			end else if (is_pop) begin
				valid_d = 1'b1;
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					occ_d = fill_m1;
					rd_d  = 1'b1;
				end
			end else if (is_list && empty) begin
				valid_d  = 1'b1;
				status_d = deq_pkg::ST_EMPTY;
			end
		end else if (cmd.list_step) begin
			valid_d = 1'b1;
			rd_d    = 1'b1;
			last_d  = sts.list_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			fill_q     <= '0;
			cnt_q      <= '0;
			list_rev_q <= 1'b0;
			valid_s1   <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			valid_s1 <= valid_d;
			strobe_q <= valid_s1;
			if (cmd.do_req && is_push && !full) begin
				fill_q <= fill_q + FW'(1);
				if (opcode == deq_pkg::OP_PUSH_FRONT) begin
					front_q <= front_dec;
				end
			end
			if (cmd.do_req && is_pop && !empty) begin
				fill_q <= fill_m1;
				if (opcode == deq_pkg::OP_POP_FRONT) begin
					front_q <= front_inc;
				end
			end
			if (cmd.list_start) begin
				cnt_q      <= '0;
				list_rev_q <= (opcode == deq_pkg::OP_LIST_REV);
			end else if (cmd.list_step) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= status_d;
		occ_s1    <= occ_d;
		last_s1   <= last_d;
		rd_s1     <= rd_d;
		element_q <= rd_s1 ? rdata : '0;
		status_q  <= status_s1;
		occ_q     <= occ_s1;
		last_q    <= last_s1;
	end

	assign strobe    = strobe_q;
	assign element   = element_q;
	assign status    = status_q;
	assign occupancy = deq_pkg::OCC_W'(occ_q);
	assign last      = last_q;

endmodule
`default_nettype wire

>>> sv/double_ended_queue_core.sv
// Push and pop: one beat accepted per cycle while not busy; result strobed through the
// valid_s1 and strobe_q registers. Listing of n elements: busy in S_LIST, one read of the
// ring RAM per cycle; results strobed one per cycle, each via valid_s1 and strobe_q.
// Empty listings strobe an EMPTY result, unused opcodes none. The receiver cannot stall.
// arst_n clears front index, fill count, controller state and strobes; RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_core #(
	parameter int DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic        [deq_pkg::OP_W-1:0]   opcode,
	input  wire logic signed [deq_pkg::DATA_W-1:0] value,
	output logic                                   strobe,
	output logic signed      [deq_pkg::DATA_W-1:0] element,
	output logic             [deq_pkg::ST_W-1:0]   status,
	output logic             [deq_pkg::OCC_W-1:0]  occupancy,
	output logic                                   last
);

	deq_pkg::cmd_t cmd;
	deq_pkg::sts_t sts;

	deq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(opcode),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	deq_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.opcode   (opcode),
		.value    (value),
		.sts      (sts),
		.strobe   (strobe),
		.element  (element),
		.status   (status),
		.occupancy(occupancy),
		.last     (last)
	);

endmodule
`default_nettype wire

>>> sv/deq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module deq_checker #(
	parameter int DEPTH = 64
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic        [deq_pkg::OP_W-1:0]   opcode,
	input wire logic                              strobe,
	input wire logic signed [deq_pkg::DATA_W-1:0] element,
	input wire logic        [deq_pkg::ST_W-1:0]   status,
	input wire logic        [deq_pkg::OCC_W-1:0]  occupancy,
	input wire logic                              last
);

	a_fail_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != deq_pkg::ST_OK) |-> (element == '0) && last)
		else $error("error beat not single or element nonzero");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == deq_pkg::ST_EMPTY) |-> (occupancy == '0))
		else $error("empty status with nonzero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == deq_pkg::ST_FULL) |-> (occupancy == deq_pkg::OCC_W'(DEPTH)))
		else $error("full status below depth");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (occupancy <= deq_pkg::OCC_W'(DEPTH)))
		else $error("occupancy beyond depth");

	a_push_pop_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((opcode == deq_pkg::OP_PUSH_FRONT)
		|| (opcode == deq_pkg::OP_PUSH_BACK) || (opcode == deq_pkg::OP_POP_FRONT)
		|| (opcode == deq_pkg::OP_POP_BACK)) |-> ##2 (strobe && last))
		else $error("push or pop result missing");

endmodule

bind double_ended_queue_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
`default_nettype wire
